FILE: sv/vjb_pkg.sv
// Shared types, codes and defaults of the voice jitter buffer.
package vjb_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [6:0] START_FRAMES_RST = 7'd3;
    localparam logic [7:0] LATE_WAIT_RST    = 8'd20;
    localparam logic [7:0] DEF_RATE_RST     = 8'd8;
    localparam logic [7:0] DEF_FRAME_RST    = 8'd20;
    localparam logic [7:0] DEF_PCM_RST      = 8'd160;

    localparam logic [CFG_IDX_W-1:0] REG_START_FRAMES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATE_WAIT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_RATE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_FRAME    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_PCM      = 8'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [2:0] {
        STAT_STORED    = 3'd0,
        STAT_STALE     = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_FRAME     = 3'd4,
        STAT_SILENCE   = 3'd5,
        STAT_NONE      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] session;
        logic [15:0] seq_num;
        logic [7:0]  codec;
        logic [7:0]  rate;
        logic [7:0]  frame;
        logic [7:0]  enc;
        logic [7:0]  pcm;
        logic [15:0] pred;
        logic [7:0]  step;
        logic [31:0] arrival;
    } slot_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot;
        logic [7:0]  codec;
        logic [7:0]  rate;
        logic [7:0]  frame;
        logic [7:0]  enc;
        logic [7:0]  pcm;
        logic [15:0] pred;
        logic [7:0]  step;
        logic [31:0] drop;
    } res_t;

endpackage

FILE: sv/voice_jitter_buffer.sv
// Voice jitter buffer top level: slot scan, insert and pop control.
//
//  channel | dir | handshake                 | content
//  s_      | in  | s_tvalid / s_tready       | insert or pop item
//  m_      | out | m_tvalid / m_tready       | one result beat per item
//  cfg_    | in  | cfg_valid / cfg_ready     | register index and value
//
// Accept to result valid: insert runs a scan pass, evaluation and result load;
// stale insert goes straight to result load. Pop runs a scan pass, one more per
// stale entry removed, then the result load. Items are accepted only in idle.
// Each pass reads every slot once through the single memory read port.
// Reset clears valid bits and control state at once; no clearing pass.
// A result waiting on m_tready does not block acceptance of the next item.
module voice_jitter_buffer
    import vjb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // session_id, sequence_req, codec, sample_rate_khz, frame_ms,
    // encoded_bytes, pcm_bytes, predictor, step_index, now_ms
    input  logic [127:0]         s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_index, out_codec, out_rate_khz, out_frame_ms, out_encoded_bytes,
    // out_pcm_bytes, out_predictor, out_step_index, dropped_count, zero pad
    output logic [103:0]         m_tdata,
    // status
    output logic [2:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    state_t          state_reg, state_next;
    logic            op_reg, op_next;
    slot_t           in_reg, in_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [15:0]     sess_reg, sess_next;
    logic [15:0]     exp_reg, exp_next;
    logic [31:0]     drop_reg, drop_next;
    logic            dup_reg, dup_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    slot_t           best_reg, best_next;
    logic [31:0]     earliest_reg, earliest_next;
    logic [CW-1:0]   count_reg, count_next;
    res_t            res_reg, res_next;
    res_t            m_res_reg, m_res_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [6:0]      start_reg;
    logic [7:0]      late_reg, def_rate_reg, def_frame_reg, def_pcm_reg;

    logic            acc;
    slot_t           in_beat;
    logic            sess_change;
    logic [15:0]     exp_in;
    logic            stale_in;
    logic            free_any;
    logic [IW-1:0]   free_idx;
    logic [15:0]     exp_eff;
    logic            enough, waited;
    logic            out_load;
    logic            wr_en, rd_en;
    logic [IW-1:0]   rd_addr;
    slot_t           rd_data;

    vjb_slot_mem #(.SLOTS(SLOTS)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data (in_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_res_reg.status;
    assign m_tdata   = {2'b00, m_res_reg.drop, m_res_reg.step, m_res_reg.pred,
                        m_res_reg.pcm, m_res_reg.enc, m_res_reg.frame,
                        m_res_reg.rate, m_res_reg.codec, m_res_reg.slot};

    always_comb begin
        in_beat.session  = s_tdata[15:0];
        in_beat.seq_num  = s_tdata[31:16];
        in_beat.codec    = s_tdata[39:32];
        in_beat.rate     = s_tdata[47:40];
        in_beat.frame    = s_tdata[55:48];
        in_beat.enc      = s_tdata[63:56];
        in_beat.pcm      = s_tdata[71:64];
        in_beat.pred     = s_tdata[87:72];
        in_beat.step     = s_tdata[95:88];
        in_beat.arrival  = s_tdata[127:96];
    end

    assign sess_change = (sess_reg != in_beat.session);
    assign exp_in      = sess_change ? in_beat.seq_num : exp_reg;
    assign stale_in    = (exp_in != 16'd0) && (in_beat.seq_num < exp_in);
    assign exp_eff     = (exp_reg == 16'd0) ? best_reg.seq_num : exp_reg;
    assign enough      = (7'(count_reg) >= start_reg);
    assign waited      = ((in_reg.arrival - earliest_reg) >= {24'd0, late_reg});
    assign out_load    = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next = (s_tuser == OP_INSERT && stale_in) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == CW'(SLOTS)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (op_reg == OP_POP && found_reg && best_reg.seq_num < exp_eff) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next       = op_reg;
        in_next       = in_reg;
        idx_next      = idx_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        valid_next    = valid_reg;
        sess_next     = sess_reg;
        exp_next      = exp_reg;
        drop_next     = drop_reg;
        dup_next      = dup_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        earliest_next = earliest_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        m_res_next    = m_res_reg;
        m_tvalid_next = m_tvalid_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    op_next    = s_tuser;
                    in_next    = in_beat;
                    idx_next   = '0;
                    dup_next   = 1'b0;
                    found_next = 1'b0;
                    count_next = '0;
                    res_next   = '0;
                    if (s_tuser == OP_INSERT) begin
                        if (sess_change) begin
                            valid_next = '0;
                            sess_next  = in_beat.session;
                            exp_next   = in_beat.seq_num;
                        end
                        if (stale_in) begin
                            res_next.status = STAT_STALE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg < CW'(SLOTS)) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IW-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (rd_vld_reg && valid_reg[rd_idx_reg]) begin
                    if (op_reg == OP_INSERT) begin
                        if (rd_data.session == in_reg.session &&
                            rd_data.seq_num == in_reg.seq_num) begin
                            dup_next = 1'b1;
                        end
                    end else begin
                        if (!found_reg || rd_data.arrival < earliest_reg) begin
                            earliest_next = rd_data.arrival;
                        end
                        if (!found_reg || rd_data.seq_num < best_reg.seq_num) begin
                            best_idx_next = rd_idx_reg;
                            best_next     = rd_data;
                        end
                        found_next = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                res_next = '0;
                if (op_reg == OP_INSERT) begin
                    if (dup_reg) begin
                        res_next.status = STAT_DUPLICATE;
                    end else if (free_any) begin
                        wr_en                = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        res_next.status      = STAT_STORED;
                        res_next.slot        = 6'(free_idx);
                    end else begin
                        drop_next       = drop_reg + 32'd1;
                        res_next.status = STAT_FULL;
                    end
                end else if (!found_reg) begin
                    res_next.status = STAT_NONE;
                end else begin
                    exp_next = exp_eff;
                    if (best_reg.seq_num < exp_eff) begin
                        valid_next[best_idx_reg] = 1'b0;
                        idx_next   = '0;
                        found_next = 1'b0;
                        count_next = '0;
                    end else if (best_reg.seq_num == exp_eff) begin
                        valid_next[best_idx_reg] = 1'b0;
                        exp_next        = exp_eff + 16'd1;
                        res_next.status = STAT_FRAME;
                        res_next.slot   = 6'(best_idx_reg);
                        res_next.codec  = best_reg.codec;
                        res_next.rate   = best_reg.rate;
                        res_next.frame  = best_reg.frame;
                        res_next.enc    = best_reg.enc;
                        res_next.pcm    = best_reg.pcm;
                        res_next.pred   = best_reg.pred;
                        res_next.step   = best_reg.step;
                    end else if (enough || waited) begin
                        exp_next        = exp_eff + 16'd1;
                        drop_next       = drop_reg + 32'd1;
                        res_next.status = STAT_SILENCE;
                        res_next.rate   = (best_reg.rate != 8'd0) ? best_reg.rate
                                                                   : def_rate_reg;
                        res_next.frame  = (best_reg.frame != 8'd0) ? best_reg.frame
                                                                    : def_frame_reg;
                        res_next.pcm    = (best_reg.pcm != 8'd0) ? best_reg.pcm
                                                                  : def_pcm_reg;
                    end else begin
                        res_next.status = STAT_NONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_res_next      = res_reg;
                    m_res_next.drop = drop_reg;
                    m_tvalid_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            sess_reg     <= '0;
            exp_reg      <= '0;
            drop_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            valid_reg    <= valid_next;
            sess_reg     <= sess_next;
            exp_reg      <= exp_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        in_reg       <= in_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        dup_reg      <= dup_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        earliest_reg <= earliest_next;
        count_reg    <= count_next;
        res_reg      <= res_next;
        m_res_reg    <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= START_FRAMES_RST;
            late_reg      <= LATE_WAIT_RST;
            def_rate_reg  <= DEF_RATE_RST;
            def_frame_reg <= DEF_FRAME_RST;
            def_pcm_reg   <= DEF_PCM_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_FRAMES: start_reg     <= cfg_data[6:0];
                REG_LATE_WAIT:    late_reg      <= cfg_data;
                REG_DEF_RATE:     def_rate_reg  <= cfg_data;
                REG_DEF_FRAME:    def_frame_reg <= cfg_data;
                REG_DEF_PCM:      def_pcm_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_write_only_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_EVAL && op_reg == OP_INSERT && !dup_reg))
        else $error("slot write outside insert evaluation");

    a_drop_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_reg != $past(drop_reg)) |-> (drop_reg == $past(drop_reg) + 32'd1))
        else $error("drop count moved by more than one");

    a_pop_never_adds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && op_reg == OP_POP)
        |=> ($countones(valid_reg) <= $past($countones(valid_reg))))
        else $error("pop added a valid slot");

    a_frame_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && res_next.status == STAT_FRAME)
        |=> !valid_reg[$past(best_idx_reg)])
        else $error("played slot still valid");
`endif

endmodule

FILE: sv/vjb_slot_mem.sv
// Slot metadata store: one write port, one registered read port.
module vjb_slot_mem
    import vjb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem [SLOTS];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the voice jitter buffer: stream driver, monitor, slot predictor.
`timescale 1ns / 100ps

module tb_top;
    import vjb_pkg::*;

    localparam int NSLOT       = 8;
    localparam int WATCH_LIMIT = 6000;
    localparam int LONG_STALL  = 400;

    typedef struct {
        logic        op;
        logic [15:0] sid;
        logic [15:0] seq;
        logic [7:0]  codec;
        logic [7:0]  rate;
        logic [7:0]  frame;
        logic [7:0]  enc;
        logic [7:0]  pcm;
        logic [15:0] pred;
        logic [7:0]  step;
        logic [31:0] now;
    } frame_item_t;

    typedef struct {
        logic [15:0] sid;
        logic [15:0] seq;
        logic [7:0]  codec;
        logic [7:0]  rate;
        logic [7:0]  frame;
        logic [7:0]  enc;
        logic [7:0]  pcm;
        logic [15:0] pred;
        logic [7:0]  step;
        logic [31:0] arrival;
    } slot_entry_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [127:0]   s_tdata;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [103:0]   m_tdata;
    logic [2:0]     m_tuser;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]     cfg_data;

    voice_jitter_buffer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // buffer state copy
    bit          buf_valid [NSLOT];
    slot_entry_t buf_slot  [NSLOT];
    logic [15:0] cur_session;
    logic [15:0] next_seq;
    logic [31:0] drops;
    logic [6:0]  start_frames;
    logic [7:0]  late_wait;
    logic [7:0]  def_rate;
    logic [7:0]  def_frame;
    logic [7:0]  def_pcm;

    frame_item_t pending_items[$];
    res_t        playout_results[$];
    int          errors;
    bit          calm;
    bit          in_taken;
    int          send_gap;
    int          recv_rest;
    int          stall_req;
    int          stall_seen;
    int          stall_left;
    int          idle_cycles;

    logic [15:0] gen_sess;
    logic [15:0] gen_base;
    logic [31:0] gen_now;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic play_next(input frame_item_t it, output res_t r);
        int          i;
        int          pass;
        int          best;
        int          cnt;
        int          free_i;
        bit          found;
        bit          stop;
        logic [31:0] earliest;
        r = '0;
        if (it.op == OP_INSERT) begin
            if (cur_session != it.sid) begin
                for (i = 0; i < NSLOT; i++) buf_valid[i] = 0;
                cur_session = it.sid;
                next_seq = it.seq;
            end
            if (next_seq != 0 && it.seq < next_seq) begin
                r.status = STAT_STALE;
            end else begin
                found = 0;
                for (i = 0; i < NSLOT; i++)
                    if (buf_valid[i] && buf_slot[i].sid == it.sid && buf_slot[i].seq == it.seq)
                        found = 1;
                free_i = -1;
                for (i = NSLOT - 1; i >= 0; i--)
                    if (!buf_valid[i]) free_i = i;
                if (found) begin
                    r.status = STAT_DUPLICATE;
                end else if (free_i < 0) begin
                    drops++;
                    r.status = STAT_FULL;
                end else begin
                    buf_valid[free_i] = 1;
                    buf_slot[free_i] = '{it.sid, it.seq, it.codec, it.rate, it.frame, it.enc,
                                         it.pcm, it.pred, it.step, it.now};
                    r.status = STAT_STORED;
                    r.slot = 6'(free_i);
                end
            end
        end else begin
            r.status = STAT_NONE;
            stop = 0;
            for (pass = 0; pass <= NSLOT && !stop; pass++) begin
                found = 0;
                cnt = 0;
                best = 0;
                earliest = '0;
                for (i = 0; i < NSLOT; i++) begin
                    if (buf_valid[i]) begin
                        if (!found || buf_slot[i].arrival < earliest)
                            earliest = buf_slot[i].arrival;
                        if (!found || buf_slot[i].seq < buf_slot[best].seq)
                            best = i;
                        found = 1;
                        cnt++;
                    end
                end
                if (!found) begin
                    stop = 1;
                end else begin
                    if (next_seq == 0) next_seq = buf_slot[best].seq;
                    if (buf_slot[best].seq < next_seq) begin
                        buf_valid[best] = 0;
                    end else begin
                        stop = 1;
                        if (buf_slot[best].seq == next_seq) begin
                            r.status = STAT_FRAME;
                            r.slot = 6'(best);
                            r.codec = buf_slot[best].codec;
                            r.rate = buf_slot[best].rate;
                            r.frame = buf_slot[best].frame;
                            r.enc = buf_slot[best].enc;
                            r.pcm = buf_slot[best].pcm;
                            r.pred = buf_slot[best].pred;
                            r.step = buf_slot[best].step;
                            buf_valid[best] = 0;
                            next_seq++;
                        end else if (cnt >= start_frames
                                     || (it.now - earliest) >= {24'd0, late_wait}) begin
                            r.status = STAT_SILENCE;
                            r.rate = buf_slot[best].rate != 0 ? buf_slot[best].rate : def_rate;
                            r.frame = buf_slot[best].frame != 0 ? buf_slot[best].frame
                                                                 : def_frame;
                            r.pcm = buf_slot[best].pcm != 0 ? buf_slot[best].pcm : def_pcm;
                            next_seq++;
                            drops++;
                        end
                    end
                end
            end
        end
        r.drop = drops;
    endtask

    function automatic frame_item_t rand_item();
        frame_item_t it;
        it.op = 1'b0;
        it.sid = 16'($urandom);
        it.seq = 16'($urandom);
        it.codec = 8'($urandom);
        it.rate = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        it.frame = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        it.enc = 8'($urandom);
        it.pcm = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        it.pred = 16'($urandom);
        it.step = 8'($urandom);
        it.now = $urandom;
        return it;
    endfunction

    task automatic add_insert(input logic [15:0] sid, input logic [15:0] seq,
                              input logic [7:0] rate, input logic [31:0] now);
        frame_item_t it;
        it = rand_item();
        it.op = OP_INSERT;
        it.sid = sid;
        it.seq = seq;
        it.rate = rate;
        it.now = now;
        pending_items.push_back(it);
    endtask

    task automatic add_pop(input logic [31:0] now);
        frame_item_t it;
        it = rand_item();
        it.op = OP_POP;
        it.now = now;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_START_FRAMES: start_frames = val[6:0];
            REG_LATE_WAIT:    late_wait = val;
            REG_DEF_RATE:     def_rate = val;
            REG_DEF_FRAME:    def_frame = val;
            REG_DEF_PCM:      def_pcm = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || playout_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            gen_now += $urandom_range(0, 12);
            case ($urandom_range(0, 39))
                0: begin
                    gen_sess = 16'($urandom);
                    gen_base = ($urandom_range(0, 3) == 0) ? 16'hFFF8 : 16'($urandom);
                end
                1, 2: pending_items.push_back(rand_item());
                default: begin
                    if ($urandom_range(0, 9) < 6) begin
                        add_insert(gen_sess, gen_base + 16'($urandom_range(0, 12)) - 16'd2,
                                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), gen_now);
                    end else begin
                        add_pop(gen_now);
                        if ($urandom_range(0, 1) == 0) gen_base++;
                    end
                end
            endcase
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            in_taken = 0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].op;
                s_tdata <= {pending_items[0].now, pending_items[0].step, pending_items[0].pred,
                            pending_items[0].pcm, pending_items[0].enc, pending_items[0].frame,
                            pending_items[0].rate, pending_items[0].codec,
                            pending_items[0].seq, pending_items[0].sid};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (recv_rest > 0) begin
            recv_rest--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_rest = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // accept beats, predict and check
    always @(posedge aclk) begin
        res_t r;
        res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready && pending_items.size() != 0) begin
                play_next(pending_items.pop_front(), r);
                playout_results.push_back(r);
                in_taken = 1;
            end
            if (m_tvalid && m_tready) begin
                if (playout_results.size() == 0) begin
                    $display("unexpected result beat at %0t", $realtime);
                    errors++;
                end else begin
                    want = playout_results.pop_front();
                    if (m_tuser != want.status)
                        report("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[5:0] != want.slot)
                        report("slot_index", 32'(m_tdata[5:0]), 32'(want.slot));
                    if (m_tdata[13:6] != want.codec)
                        report("codec", 32'(m_tdata[13:6]), 32'(want.codec));
                    if (m_tdata[21:14] != want.rate)
                        report("rate", 32'(m_tdata[21:14]), 32'(want.rate));
                    if (m_tdata[29:22] != want.frame)
                        report("frame_ms", 32'(m_tdata[29:22]), 32'(want.frame));
                    if (m_tdata[37:30] != want.enc)
                        report("encoded", 32'(m_tdata[37:30]), 32'(want.enc));
                    if (m_tdata[45:38] != want.pcm)
                        report("pcm", 32'(m_tdata[45:38]), 32'(want.pcm));
                    if (m_tdata[61:46] != want.pred)
                        report("predictor", 32'(m_tdata[61:46]), 32'(want.pred));
                    if (m_tdata[69:62] != want.step)
                        report("step", 32'(m_tdata[69:62]), 32'(want.step));
                    if (m_tdata[101:70] != want.drop)
                        report("dropped", m_tdata[101:70], want.drop);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int ph;
        int k;
        errors = 0;
        calm = 0;
        in_taken = 0;
        send_gap = 0;
        recv_rest = 0;
        stall_req = 0;
        stall_seen = 0;
        stall_left = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (k = 0; k < NSLOT; k++) buf_valid[k] = 0;
        cur_session = '0;
        next_seq = '0;
        drops = '0;
        start_frames = START_FRAMES_RST;
        late_wait = LATE_WAIT_RST;
        def_rate = DEF_RATE_RST;
        def_frame = DEF_FRAME_RST;
        def_pcm = DEF_PCM_RST;
        gen_sess = 16'h0042;
        gen_base = 16'd1;
        gen_now = 32'hFFFF_FF00;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: in-order play, reordering, duplicate, stale, overflow
        add_insert(16'h1234, 16'd5, 8'd16, 32'd0);
        add_insert(16'h1234, 16'd7, 8'd16, 32'd1);
        add_insert(16'h1234, 16'd6, 8'd16, 32'd2);
        add_insert(16'h1234, 16'd6, 8'd16, 32'd3);
        add_insert(16'h1234, 16'd3, 8'd16, 32'd3);
        repeat (4) add_pop(32'd4);
        for (k = 10; k < 18; k++) add_insert(16'h1234, 16'(k), 8'd0, 32'd5);
        add_insert(16'h1234, 16'd18, 8'd0, 32'd6);
        add_pop(32'd7);
        // session change, wait-based skip
        add_insert(16'h0077, 16'd50, 8'd8, 32'd100);
        add_insert(16'h0077, 16'd52, 8'd8, 32'd100);
        add_pop(32'd101);
        add_pop(32'd102);
        add_pop(32'd130);
        add_pop(32'd131);
        settle();

        // field extremes, expected wrap to unset
        write_reg(REG_START_FRAMES, 8'd1);
        write_reg(REG_LATE_WAIT, 8'd1);
        write_reg(REG_DEF_RATE, 8'd1);
        write_reg(REG_DEF_FRAME, 8'd1);
        write_reg(REG_DEF_PCM, 8'd1);
        pending_items.push_back('{OP_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  8'hFF, 16'h7FFF, 8'hFF, 32'hFFFF_FFFF});
        add_pop(32'd0);
        pending_items.push_back('{OP_INSERT, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 16'h8000, 8'h00, 32'h0000_0000});
        add_pop(32'd0);
        add_pop(32'd0);
        random_phase(100);
        settle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_START_FRAMES, 8'd64);
                    write_reg(REG_LATE_WAIT, 8'd255);
                    write_reg(REG_DEF_RATE, 8'd255);
                    write_reg(REG_DEF_FRAME, 8'd255);
                    write_reg(REG_DEF_PCM, 8'd255);
                    stall_req++;
                end
                1: begin
                    write_reg(REG_START_FRAMES, 8'd0);
                    write_reg(REG_LATE_WAIT, 8'd20);
                end
                2: write_reg(REG_START_FRAMES, 8'd127);
                5: begin
                    write_reg(REG_START_FRAMES, {1'b0, START_FRAMES_RST});
                    write_reg(REG_LATE_WAIT, LATE_WAIT_RST);
                    write_reg(REG_DEF_RATE, DEF_RATE_RST);
                    write_reg(REG_DEF_FRAME, DEF_FRAME_RST);
                    write_reg(REG_DEF_PCM, DEF_PCM_RST);
                    calm = 1;
                end
                default: begin
                    write_reg(REG_START_FRAMES, 8'($urandom_range(1, 64)));
                    write_reg(REG_LATE_WAIT, 8'($urandom_range(1, 255)));
                    write_reg(REG_DEF_RATE, 8'($urandom_range(1, 255)));
                    write_reg(REG_DEF_FRAME, 8'($urandom_range(1, 255)));
                    write_reg(REG_DEF_PCM, 8'($urandom_range(1, 255)));
                    write_reg(8'd200, 8'($urandom));
                end
            endcase
            random_phase(115);
            settle();
        end

        repeat (150) @(posedge aclk);
        if (errors == 0 && playout_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            if (playout_results.size() != 0)
                $display("%0d results never arrived", playout_results.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
